FILE: rtl/mlpfi_pkg.sv
`default_nettype none
package mlpfi_pkg;

  localparam int FEATURE_COUNT     = 7;
  localparam int FIRST_LAYER_SIZE  = 20;
  localparam int SECOND_LAYER_SIZE = 10;
  localparam int PARAM_WORDS       = 512;
  localparam int SIGMOID_ENTRIES   = 1024;

  localparam int FEATURE_FIELDS = 7;
  localparam int DATA_W         = 16;
  localparam int PRED_W         = 13;
  localparam int PROD_W         = 32;
  localparam int ACC_W          = 40;
  localparam int FRAC_BITS      = 12;
  localparam int LANES          = 2;

  localparam int PARAM_AW   = $clog2(PARAM_WORDS);
  localparam int BANK_DEPTH = PARAM_WORDS / LANES;
  localparam int BANK_AW    = PARAM_AW - 1;

  // parameter memory layout
  localparam int W2_BASE = FEATURE_COUNT * FIRST_LAYER_SIZE;
  localparam int W3_BASE = W2_BASE + FIRST_LAYER_SIZE * SECOND_LAYER_SIZE;
  localparam int B1_BASE = W3_BASE + SECOND_LAYER_SIZE;
  localparam int B2_BASE = B1_BASE + FIRST_LAYER_SIZE;
  localparam int B3_BASE = B2_BASE + SECOND_LAYER_SIZE;

  localparam int MAX_DIM_A = (FEATURE_COUNT > FIRST_LAYER_SIZE) ? FEATURE_COUNT
                                                                : FIRST_LAYER_SIZE;
  localparam int MAX_DIM   = (MAX_DIM_A > SECOND_LAYER_SIZE) ? MAX_DIM_A
                                                             : SECOND_LAYER_SIZE;
  localparam int CNT_W     = $clog2(MAX_DIM + 3);

  localparam int FEAT_IW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int H1_IW   = (FIRST_LAYER_SIZE > 1) ? $clog2(FIRST_LAYER_SIZE) : 1;
  localparam int H2_IW   = (SECOND_LAYER_SIZE > 1) ? $clog2(SECOND_LAYER_SIZE) : 1;

  localparam int SIG_IW    = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_SHIFT = DATA_W - SIG_IW;

  localparam logic signed [DATA_W-1:0] BIAS_SCALE = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] Q_MAX      = DATA_W'(32767);
  localparam logic signed [DATA_W-1:0] Q_MIN      = DATA_W'(-32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ACT,
    ST_HOLD
  } state_e;

  typedef enum logic [1:0] {
    LYR_HID1,
    LYR_HID2,
    LYR_OUT
  } layer_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_INFER = 1'b1
  } opcode_e;

  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctl_t;

  typedef logic [SIGMOID_ENTRIES-1:0][PRED_W-1:0] sig_lut_t;

  // shift-subtract quotient of two nonnegative values, table build only
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // sigmoid at the center of each input cell, exp(-|x|) by truncated series
  function automatic sig_lut_t build_sigmoid_lut();
    sig_lut_t lut;
    longint   m;
    longint   mag;
    longint   a;
    longint   f;
    longint   whole;
    longint   sum;
    longint   term;
    longint   den;
    longint   num;
    logic     stop;
    lut = '0;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      m     = 2 * longint'(k) + 1 - SIGMOID_ENTRIES;
      mag   = (m < 0) ? -m : m;
      a     = (mag <<< 33) >>> SIG_IW;
      f     = a & ((longint'(1) <<< 30) - 1);
      whole = a >>> 30;
      sum   = longint'(1) <<< 30;
      term  = longint'(1) <<< 30;
      stop  = 1'b0;
      for (int n = 1; n < 40; n++) begin
        if (!stop) begin
          term = (term * f) >>> 30;
          term = udiv(term, longint'(n));
          if (term == 0) begin
            stop = 1'b1;
          end else if ((n & 1) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      for (longint w = 0; w < whole; w++) begin
        sum = (sum * 395007542) >>> 30;
      end
      den    = (longint'(1) <<< 30) + sum;
      num    = (m >= 0) ? (longint'(1) <<< 30) : sum;
      lut[k] = PRED_W'(udiv(4096 * num * 2 + den, 2 * den));
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sigmoid_lut();

endpackage
`default_nettype wire

FILE: rtl/mlpfi_ram.sv
`default_nettype none
module mlpfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/mlpfi_lane.sv
`default_nettype none
module mlpfi_lane (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire mlpfi_pkg::mac_ctl_t                    ctl_i,
  input  wire logic signed [mlpfi_pkg::DATA_W-1:0]    weight_i,
  input  wire logic signed [mlpfi_pkg::DATA_W-1:0]    operand_i,
  output logic signed      [mlpfi_pkg::ACC_W-1:0]     acc_o
);

  logic signed [mlpfi_pkg::PROD_W-1:0] prod_q;
  mlpfi_pkg::mac_ctl_t                 pctl_q;
  logic signed [mlpfi_pkg::ACC_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    prod_q <= weight_i * operand_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (pctl_q.vld) begin
      if (pctl_q.first) begin
        acc_d = mlpfi_pkg::ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + mlpfi_pkg::ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
      acc_q  <= '0;
    end else begin
      pctl_q <= ctl_i;
      acc_q  <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

FILE: rtl/mlpfi_merge.sv
`default_nettype none
module mlpfi_merge (
  input  wire logic signed [mlpfi_pkg::ACC_W-1:0] acc_i [mlpfi_pkg::LANES],
  output logic             [mlpfi_pkg::PRED_W-1:0] act_o [mlpfi_pkg::LANES]
);

  localparam int QW = mlpfi_pkg::ACC_W - mlpfi_pkg::FRAC_BITS;

  logic signed [QW-1:0]                  q     [mlpfi_pkg::LANES];
  logic signed [mlpfi_pkg::DATA_W-1:0]   qs    [mlpfi_pkg::LANES];
  logic        [mlpfi_pkg::DATA_W-1:0]   biased[mlpfi_pkg::LANES];
  logic        [mlpfi_pkg::SIG_IW-1:0]   idx   [mlpfi_pkg::LANES];

  // floor to Q4.12, saturate, offset-binary top bits pick the table cell
  always_comb begin
    for (int l = 0; l < mlpfi_pkg::LANES; l++) begin
      q[l] = QW'(acc_i[l] >>> mlpfi_pkg::FRAC_BITS);
      if (q[l] > QW'(mlpfi_pkg::Q_MAX)) begin
        qs[l] = mlpfi_pkg::Q_MAX;
      end else if (q[l] < QW'(mlpfi_pkg::Q_MIN)) begin
        qs[l] = mlpfi_pkg::Q_MIN;
      end else begin
        qs[l] = q[l][mlpfi_pkg::DATA_W-1:0];
      end
      biased[l] = {~qs[l][mlpfi_pkg::DATA_W-1], qs[l][mlpfi_pkg::DATA_W-2:0]};
      idx[l]    = biased[l][mlpfi_pkg::DATA_W-1:mlpfi_pkg::SIG_SHIFT];
      act_o[l]  = mlpfi_pkg::SIG_LUT[idx[l]];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mlp_forward_inference.sv
// Forward pass of a fully connected 7-20-10-1 sigmoid network, Q4.12 data.
// Input channel (in_valid_i/in_ready_o): opcode 0 writes param_value_i at
// param_address_i into the parameter memory; the beat gives no result.
// Opcode 1 runs inference on feature_0_i..feature_6_i
// and returns one output beat (out_valid_o/out_ready_i) carrying the
// prediction and target minus prediction.
// Two MAC lanes compute two neurons of a layer at once; the parameter memory
// is split into even and odd banks so both lanes read a weight each issue cycle.
// A neuron pair with fan-in K issues K+1 terms (bias and K weights), then
// drains the MAC pipeline and takes the activation; after the output neuron
// the result is loaded into the output register. in_ready_o is high only
// while the engine is idle; a finished result sits in the output register,
// and the next item is accepted while it waits. If the receiver stalls with
// a result still held, the next inference finishes and waits in its last
// state until the output register frees. Reset clears control state and
// the accumulators; the parameter memory and layer values are undefined
// until written.
`default_nettype none
module mlp_forward_inference (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [8:0]  param_address_i,
  input  wire logic signed [15:0] param_value_i,
  input  wire logic signed [15:0] feature_0_i,
  input  wire logic signed [15:0] feature_1_i,
  input  wire logic signed [15:0] feature_2_i,
  input  wire logic signed [15:0] feature_3_i,
  input  wire logic signed [15:0] feature_4_i,
  input  wire logic signed [15:0] feature_5_i,
  input  wire logic signed [15:0] feature_6_i,
  input  wire logic signed [15:0] target_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [12:0]      prediction_o,
  output logic signed [15:0] error_o
);

  localparam int DW  = mlpfi_pkg::DATA_W;
  localparam int AW  = mlpfi_pkg::PARAM_AW;
  localparam int CW  = mlpfi_pkg::CNT_W;
  localparam int PW  = mlpfi_pkg::PRED_W;
  localparam int F   = mlpfi_pkg::FEATURE_COUNT;
  localparam int H1  = mlpfi_pkg::FIRST_LAYER_SIZE;
  localparam int H2  = mlpfi_pkg::SECOND_LAYER_SIZE;
  localparam int NL  = mlpfi_pkg::LANES;

  mlpfi_pkg::state_e state_q, state_d;
  mlpfi_pkg::layer_e layer_q, layer_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     j_q, j_d;
  logic              drain_q, drain_d;
  logic [AW-1:0]     w_addr_q, w_addr_d;

  logic signed [DW-1:0] feat_q [F];
  logic signed [DW-1:0] target_q;
  logic signed [DW-1:0] l1_q [H1];
  logic signed [DW-1:0] l2_q [H2];

  logic          out_valid_q;
  logic [PW-1:0] out_pred_q;
  logic signed [DW-1:0] out_err_q;

  // FSM outputs
  logic do_issue, do_act, do_load, last_term, last_pair;

  // layer geometry
  logic [CW-1:0] fanin, lsize;
  logic [AW-1:0] bias_base, w_base, w_stride;

  always_comb begin
    case (layer_q)
      mlpfi_pkg::LYR_HID1: begin
        fanin     = CW'(F);
        lsize     = CW'(H1);
        bias_base = AW'(mlpfi_pkg::B1_BASE);
        w_base    = AW'(0);
        w_stride  = AW'(H1);
      end
      mlpfi_pkg::LYR_HID2: begin
        fanin     = CW'(H1);
        lsize     = CW'(H2);
        bias_base = AW'(mlpfi_pkg::B2_BASE);
        w_base    = AW'(mlpfi_pkg::W2_BASE);
        w_stride  = AW'(H2);
      end
      default: begin
        fanin     = CW'(H2);
        lsize     = CW'(1);
        bias_base = AW'(mlpfi_pkg::B3_BASE);
        w_base    = AW'(mlpfi_pkg::W3_BASE);
        w_stride  = AW'(1);
      end
    endcase
  end

  logic [CW-1:0] n_next;
  assign last_term = (j_q == fanin);
  assign n_next    = n_q + CW'(NL);
  assign last_pair = (n_next >= lsize);

  logic in_acc;
  assign in_ready_o = (state_q == mlpfi_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlpfi_pkg::ST_IDLE: begin
        if (in_acc && (opcode_i == mlpfi_pkg::OP_INFER)) begin
          state_d = mlpfi_pkg::ST_ISSUE;
        end
      end
      mlpfi_pkg::ST_ISSUE: begin
        if (last_term) begin
          state_d = mlpfi_pkg::ST_DRAIN;
        end
      end
      mlpfi_pkg::ST_DRAIN: begin
        if (drain_q) begin
          state_d = mlpfi_pkg::ST_ACT;
        end
      end
      mlpfi_pkg::ST_ACT: begin
        if (last_pair && (layer_q == mlpfi_pkg::LYR_OUT)) begin
          state_d = mlpfi_pkg::ST_HOLD;
        end else begin
          state_d = mlpfi_pkg::ST_ISSUE;
        end
      end
      mlpfi_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = mlpfi_pkg::ST_IDLE;
        end
      end
      default: state_d = mlpfi_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    do_issue = 1'b0;
    do_act   = 1'b0;
    do_load  = 1'b0;
    case (state_q)
      mlpfi_pkg::ST_ISSUE: do_issue = 1'b1;
      mlpfi_pkg::ST_ACT:   do_act   = 1'b1;
      mlpfi_pkg::ST_HOLD:  do_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // sequencing counters
  always_comb begin
    layer_d  = layer_q;
    n_d      = n_q;
    j_d      = j_q;
    drain_d  = 1'b0;
    w_addr_d = w_addr_q;
    if (in_acc && (opcode_i == mlpfi_pkg::OP_INFER)) begin
      layer_d = mlpfi_pkg::LYR_HID1;
      n_d     = '0;
      j_d     = '0;
    end
    if (do_issue) begin
      if (j_q == '0) begin
        w_addr_d = w_base + AW'(n_q);
      end else begin
        w_addr_d = w_addr_q + w_stride;
      end
      j_d = last_term ? '0 : j_q + CW'(1);
    end
    if (state_q == mlpfi_pkg::ST_DRAIN) begin
      drain_d = !drain_q;
    end
    if (do_act) begin
      if (last_pair) begin
        n_d = '0;
        case (layer_q)
          mlpfi_pkg::LYR_HID1: layer_d = mlpfi_pkg::LYR_HID2;
          default:             layer_d = mlpfi_pkg::LYR_OUT;
        endcase
      end else begin
        n_d = n_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mlpfi_pkg::ST_IDLE;
      layer_q  <= mlpfi_pkg::LYR_HID1;
      n_q      <= '0;
      j_q      <= '0;
      drain_q  <= 1'b0;
      w_addr_q <= '0;
    end else begin
      state_q  <= state_d;
      layer_q  <= layer_d;
      n_q      <= n_d;
      j_q      <= j_d;
      drain_q  <= drain_d;
      w_addr_q <= w_addr_d;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == mlpfi_pkg::OP_INFER)) begin
      for (int f = 0; f < F; f++) begin
        case (f)
          0:       feat_q[f] <= feature_0_i;
          1:       feat_q[f] <= feature_1_i;
          2:       feat_q[f] <= feature_2_i;
          3:       feat_q[f] <= feature_3_i;
          4:       feat_q[f] <= feature_4_i;
          5:       feat_q[f] <= feature_5_i;
          6:       feat_q[f] <= feature_6_i;
          default: feat_q[f] <= '0;
        endcase
      end
      target_q <= target_i;
    end
  end

  // term issue: address and operand
  logic [AW-1:0]        addr0, addr1;
  logic [CW-1:0]        jm1;
  logic signed [DW-1:0] operand;

  assign addr0 = (j_q == '0) ? (bias_base + AW'(n_q)) : w_addr_q;
  assign addr1 = addr0 + AW'(1);
  assign jm1   = j_q - CW'(1);

  always_comb begin
    if (j_q == '0) begin
      operand = mlpfi_pkg::BIAS_SCALE;
    end else begin
      case (layer_q)
        mlpfi_pkg::LYR_HID1: operand = feat_q[jm1[mlpfi_pkg::FEAT_IW-1:0]];
        mlpfi_pkg::LYR_HID2: operand = l1_q[jm1[mlpfi_pkg::H1_IW-1:0]];
        default:             operand = l2_q[jm1[mlpfi_pkg::H2_IW-1:0]];
      endcase
    end
  end

  // parameter memory: even and odd banks
  logic                             wr_en;
  logic [mlpfi_pkg::BANK_AW-1:0]    bank_raddr [NL];
  logic [DW-1:0]                    bank_rdata [NL];

  assign wr_en = in_acc && (opcode_i == mlpfi_pkg::OP_WRITE);

  assign bank_raddr[0] = addr0[0] ? addr1[AW-1:1] : addr0[AW-1:1];
  assign bank_raddr[1] = addr0[0] ? addr0[AW-1:1] : addr1[AW-1:1];

  for (genvar b = 0; b < NL; b++) begin : g_bank
    mlpfi_ram #(
      .WIDTH(DW),
      .DEPTH(mlpfi_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en && (param_address_i[0] == 1'(b))),
      .waddr_i(param_address_i[AW-1:1]),
      .wdata_i(param_value_i),
      .raddr_i(bank_raddr[b]),
      .rdata_o(bank_rdata[b])
    );
  end

  // read stage, aligned with the registered memory data
  mlpfi_pkg::mac_ctl_t  rd_ctl_q;
  logic                 rd_sel_q;
  logic signed [DW-1:0] rd_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q.vld   <= do_issue;
      rd_ctl_q.first <= do_issue && (j_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sel_q <= addr0[0];
    rd_x_q   <= operand;
  end

  logic signed [mlpfi_pkg::ACC_W-1:0] acc [NL];
  logic        [PW-1:0]               act [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic signed [DW-1:0] weight;
    assign weight = (rd_sel_q ^ 1'(l)) ? bank_rdata[1] : bank_rdata[0];

    mlpfi_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (rd_ctl_q),
      .weight_i (weight),
      .operand_i(rd_x_q),
      .acc_o    (acc[l])
    );
  end

  mlpfi_merge u_merge (
    .acc_i(acc),
    .act_o(act)
  );

  // layer value write-back
  always_ff @(posedge clk_i) begin
    if (do_act) begin
      for (int e = 0; e < H1; e++) begin
        if (layer_q == mlpfi_pkg::LYR_HID1) begin
          if (n_q == CW'(e)) begin
            l1_q[e] <= DW'(act[0]);
          end else if (n_q + CW'(1) == CW'(e)) begin
            l1_q[e] <= DW'(act[1]);
          end
        end
      end
      for (int e = 0; e < H2; e++) begin
        if (layer_q == mlpfi_pkg::LYR_HID2) begin
          if (n_q == CW'(e)) begin
            l2_q[e] <= DW'(act[0]);
          end else if (n_q + CW'(1) == CW'(e)) begin
            l2_q[e] <= DW'(act[1]);
          end
        end
      end
    end
  end

  // prediction held from the output activation until the result loads
  logic [PW-1:0]          pred_q;
  logic signed [DW:0]     diff;
  logic signed [DW-1:0]   err_sat;

  always_ff @(posedge clk_i) begin
    if (do_act && (layer_q == mlpfi_pkg::LYR_OUT)) begin
      pred_q <= act[0];
    end
  end

  assign diff = {target_q[DW-1], target_q} - $signed({{(DW+1-PW){1'b0}}, pred_q});

  always_comb begin
    if (diff > (DW+1)'(mlpfi_pkg::Q_MAX)) begin
      err_sat = mlpfi_pkg::Q_MAX;
    end else if (diff < $signed({mlpfi_pkg::Q_MIN[DW-1], mlpfi_pkg::Q_MIN})) begin
      err_sat = mlpfi_pkg::Q_MIN;
    end else begin
      err_sat = diff[DW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      out_pred_q <= pred_q;
      out_err_q  <= err_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;
  assign error_o      = out_err_q;

  // the MAC pipeline must be empty when activations are taken
  a_act_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlpfi_pkg::ST_ACT) |-> !rd_ctl_q.vld)
    else $error("activation taken with MAC terms in flight");

  // a result only appears after the output neuron has finished
  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == mlpfi_pkg::ST_HOLD))
    else $error("result raised outside of hold state");

  a_pred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |-> (pred_q <= PW'(1 << mlpfi_pkg::FRAC_BITS)))
    else $error("prediction above 1.0");

  a_drain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == mlpfi_pkg::ST_ISSUE && state_q == mlpfi_pkg::ST_DRAIN)
      |=> state_q == mlpfi_pkg::ST_DRAIN ##1 state_q == mlpfi_pkg::ST_ACT)
    else $error("pipeline drain length wrong");

endmodule
`default_nettype wire
